FILE: rtl/dshot_cs_pkg.sv
// ----------------------------------------------------------------------------
// dshot_cs_pkg
// Shared types and constants for the DShot command scheduler.
// ----------------------------------------------------------------------------
package dshot_cs_pkg;

  // Default number of entries in the beep queue
  localparam int unsigned QueueDepthDefault = 16;

  // Command codes as carried on the input tuser
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_THROTTLE = 2'd1;
  localparam logic [1:0] CMD_BEEP     = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Field widths
  localparam int unsigned ValueW = 11;
  localparam int unsigned PauseW = 16;
  localparam int unsigned FrameW = 16;

  // Classified request kinds handed from the front to the back
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_THROTTLE = 2'd1,
    KIND_BEEP     = 2'd2,
    KIND_NOP      = 2'd3
  } kind_e;

  // One classified request
  typedef struct packed {
    kind_e              kind;
    logic [ValueW-1:0]  value;
    logic [PauseW-1:0]  pause;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic               entry_dropped;
    logic [FrameW-1:0]  line_word;
    logic [FrameW-1:0]  frame;
    logic               frame_sent;
  } result_t;

endpackage

FILE: rtl/dshot_cs_front.sv
// ----------------------------------------------------------------------------
// dshot_cs_front
// Accepts input requests, classifies the command code and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dshot_cs_front import dshot_cs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input request
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_command_i,
  input  logic [ValueW-1:0]  in_value_i,
  input  logic [PauseW-1:0]  in_pause_i,
  // classified request to back end
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  kind_e      kind;
  cmd_t       cmd_in;
  logic       push, pop;

  // Command decode
  always_comb begin
    unique case (in_command_i)
      CMD_TICK:     kind = KIND_TICK;
      CMD_THROTTLE: kind = KIND_THROTTLE;
      CMD_BEEP:     kind = KIND_BEEP;
      CMD_UNUSED:   kind = KIND_NOP;
      default:      kind = KIND_NOP;
    endcase
  end

  assign cmd_in = '{kind: kind, value: in_value_i, pause: in_pause_i};

  // Queue handshake
  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/dshot_cs_back.sv
// ----------------------------------------------------------------------------
// dshot_cs_back
// Carries out classified requests: standing throttle, pause countdown,
// beep queue in memory and frame build, with a registered result slot.
// ----------------------------------------------------------------------------
module dshot_cs_back import dshot_cs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     invert_i,
  // classified request from front end
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  cmd_t     cmd_i,
  // result
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [ValueW-1:0] TelemLimit = ValueW'(48);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic               state_q, state_d;
  logic [ValueW-1:0]  throttle_q, throttle_d;
  logic [PauseW-1:0]  pause_q, pause_d;
  logic [PtrW-1:0]    head_q, head_d;
  logic [PtrW-1:0]    tail_q, tail_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;
  result_t            res_d;
  logic               res_we;
  logic               mem_we, mem_re;
  logic               out_free;

  logic [ValueW-1:0]  tone_mem  [QUEUE_DEPTH];
  logic [PauseW-1:0]  pause_mem [QUEUE_DEPTH];
  logic [ValueW-1:0]  rd_tone_q;
  logic [PauseW-1:0]  rd_pause_q;

  // value, telemetry bit, nibble-XOR checksum (complemented when inverted)
  function automatic result_t build_frame(logic [ValueW-1:0] val, logic telem,
                                          logic inv);
    logic [ValueW:0]   word;
    logic [3:0]        sum;
    result_t           r;
    word = {val, telem};
    sum  = word[3:0] ^ word[7:4] ^ word[11:8];
    if (inv) begin
      sum = ~sum;
    end
    r               = '0;
    r.frame_sent    = 1'b1;
    r.frame         = {word, sum};
    r.line_word     = inv ? ~{word, sum} : {word, sum};
    return r;
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free    = !out_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Request sequencer
  always_comb begin
    state_d    = state_q;
    throttle_d = throttle_q;
    pause_d    = pause_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    res_d      = '0;
    res_we     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          case (cmd_i.kind)
            KIND_TICK: begin
              if (pause_q != '0) begin
                pause_d = pause_q - 1'b1;
                res_we  = 1'b1;
              end else if (fill_q != '0) begin
                // oldest entry: fetch from memory, build next cycle
                mem_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                res_d  = build_frame(throttle_q,
                                     (throttle_q != '0) && (throttle_q < TelemLimit),
                                     invert_i);
                res_we = 1'b1;
              end
            end
            KIND_THROTTLE: begin
              throttle_d = cmd_i.value;
              res_we     = 1'b1;
            end
            KIND_BEEP: begin
              if (fill_q == FillW'(QUEUE_DEPTH)) begin
                res_d.entry_dropped = 1'b1;
              end else begin
                mem_we = 1'b1;
                tail_d = ptr_inc(tail_q);
                fill_d = fill_q + 1'b1;
              end
              res_we = 1'b1;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_d   = build_frame(rd_tone_q, 1'b1, invert_i);
        res_we  = 1'b1;
        head_d  = ptr_inc(head_q);
        fill_d  = fill_q - 1'b1;
        if (rd_pause_q != '0) begin
          pause_d = rd_pause_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      throttle_q  <= '0;
      pause_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      throttle_q  <= throttle_d;
      pause_q     <= pause_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      out_q <= res_d;
    end
  end

  // Beep queue memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tone_mem[tail_q]  <= cmd_i.value;
      pause_mem[tail_q] <= cmd_i.pause;
    end
    if (mem_re) begin
      rd_tone_q  <= tone_mem[head_q];
      rd_pause_q <= pause_mem[head_q];
    end
  end

endmodule

FILE: rtl/dshot_command_scheduler.sv
// DShot frame scheduler for one motor channel. Requests enter on the s_axis
// stream (tuser = command: tick, set throttle, queue beep) and every request
// returns exactly one result on m_axis. A request passes a two-entry front
// queue and is then carried out by the back end; a tick that sends the oldest
// queued beep also passes the ST_READ state in the back end because the beep
// queue memory has a registered read port. Sustained rate is therefore one
// request per cycle provided m_axis_tready stays high, but the back end takes
// no new request while it is in ST_READ. invert_mode (APB address 0, bit 0)
// selects inverted DShot and is applied when a frame is built.
// ----------------------------------------------------------------------------
// dshot_command_scheduler
// Top level: APB register, front/back split and stream packing.
// ----------------------------------------------------------------------------
module dshot_command_scheduler import dshot_cs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [10:0] value, [26:11] pause_ticks
  input  logic [1:0]   s_axis_tuser,   // [1:0] command
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // [15:0] frame, [31:16] line_word
  output logic [1:0]   m_axis_tuser    // [0] frame_sent, [1] entry_dropped
);

  localparam logic REG_INVERT = 1'b0;

  logic     invert_q;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;
  result_t  res;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INVERT)) begin
      invert_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_INVERT) ? {31'd0, invert_q} : 32'd0;

  dshot_cs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_command_i (s_axis_tuser),
    .in_value_i   (s_axis_tdata[ValueW-1:0]),
    .in_pause_i   (s_axis_tdata[ValueW+PauseW-1:ValueW]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  dshot_cs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .invert_i    (invert_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Result packing
  assign m_axis_tdata = {res.line_word, res.frame};
  assign m_axis_tuser = {res.entry_dropped, res.frame_sent};

endmodule

FILE: rtl/dshot_cs_checker.sv
// ----------------------------------------------------------------------------
// dshot_cs_checker
// Port-level checks on the scheduler's result stream, bound to the top.
// ----------------------------------------------------------------------------
module dshot_cs_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser
);

  logic [3:0] nib_xor;
  assign nib_xor = m_axis_tdata[15:12] ^ m_axis_tdata[11:8] ^
                   m_axis_tdata[7:4] ^ m_axis_tdata[3:0];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no frame means zero frame and line word
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("frame data without frame_sent");

  // a sent frame never reports a dropped entry
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("frame_sent and entry_dropped together");

  // checksum polarity agrees with line inversion
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (nib_xor == 4'h0 && m_axis_tdata[31:16] == m_axis_tdata[15:0]) ||
      (nib_xor == 4'hF && m_axis_tdata[31:16] == ~m_axis_tdata[15:0]))
    else $error("checksum and line polarity disagree");

endmodule

bind dshot_command_scheduler dshot_cs_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/dshot_command_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_command_scheduler_tb
// Self-checking bench for the DShot command scheduler. A directed table covers
// reset state, throttle telemetry edges, beep queue overflow, pause countdown
// and inverted mode; random phases then mix requests under random idling and
// back-pressure. Results are checked against fixed rows or a frame predictor.
// ----------------------------------------------------------------------------
module dshot_command_scheduler_tb import dshot_cs_pkg::*; ();

  localparam int unsigned QDEPTH          = QueueDepthDefault;
  localparam int unsigned TELEM_LIMIT     = 48;
  localparam int unsigned REG_INVERT_MODE = 0;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned PHASE_REQS      = 230;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // one line of the directed table; cfg rows carry the register value in val
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  cmd;
    logic [10:0] val;
    logic [15:0] pause;
    int unsigned reps;
    bit          fixed;
    result_t     res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [10:0] value, [26:11] pause_ticks
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;        // [15:0] frame, [31:16] line_word
  logic [1:0]  m_axis_tuser;        // [0] frame_sent, [1] entry_dropped

  // predictor state
  bit          inv_mode;
  logic [10:0] thr_setting;
  logic [15:0] pause_left;
  logic [10:0] beep_tone [QDEPTH];
  logic [15:0] beep_pause [QDEPTH];
  logic [3:0]  beep_head;
  logic [4:0]  beep_fill;

  result_t     expected_frames [$];
  int unsigned mismatches = 0;
  int unsigned req_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_gap_pct = 20;
  int unsigned rx_stall_pct = 20;
  int unsigned rx_hold = 0;
  bit          long_hold_req = 1'b0;
  stim_row_t   dir_table [$];

  dshot_command_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // value, telemetry bit, nibble XOR checksum (complemented when inverted)
  function automatic logic [15:0] make_dshot_frame(logic [10:0] val, logic telem);
    logic [11:0] w;
    logic [3:0]  crc;
    w   = {val, telem};
    crc = w[3:0] ^ w[7:4] ^ w[11:8];
    if (inv_mode) crc = ~crc;
    return {w, crc};
  endfunction

  // advance the scheduler state by one request and return its result
  function automatic result_t predict_frame(logic [1:0] cmd, logic [10:0] val,
                                            logic [15:0] pause);
    result_t r;
    logic [3:0] slot;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        if (pause_left != 0) begin
          pause_left = pause_left - 1'b1;
        end else if (beep_fill != 0) begin
          r.frame      = make_dshot_frame(beep_tone[beep_head], 1'b1);
          r.frame_sent = 1'b1;
          if (beep_pause[beep_head] != 0) pause_left = beep_pause[beep_head];
          beep_head = beep_head + 1'b1;
          beep_fill = beep_fill - 1'b1;
        end else begin
          r.frame = make_dshot_frame(thr_setting,
                                     thr_setting != 0 && thr_setting < TELEM_LIMIT);
          r.frame_sent = 1'b1;
        end
        if (r.frame_sent) r.line_word = inv_mode ? ~r.frame : r.frame;
      end
      CMD_THROTTLE: thr_setting = val;
      CMD_BEEP: begin
        if (beep_fill >= QDEPTH) begin
          r.entry_dropped = 1'b1;
        end else begin
          slot = 4'((beep_head + beep_fill) % QDEPTH);
          beep_tone[slot]  = val;
          beep_pause[slot] = pause;
          beep_fill = beep_fill + 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic result_t res(logic sent, logic [15:0] frame, logic [15:0] line,
                                  logic drop);
    result_t r;
    r.frame_sent    = sent;
    r.frame         = frame;
    r.line_word     = line;
    r.entry_dropped = drop;
    return r;
  endfunction

  function automatic stim_row_t row(row_kind_e k, logic [1:0] cmd, logic [10:0] val,
                                    logic [15:0] pause, int unsigned reps, bit fixed,
                                    result_t r);
    stim_row_t s;
    s.kind  = k;
    s.cmd   = cmd;
    s.val   = val;
    s.pause = pause;
    s.reps  = reps;
    s.fixed = fixed;
    s.res   = r;
    return s;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // throttle/tone values biased toward the telemetry range and its edges
  function automatic logic [10:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 11'($urandom_range(0, 60));
    if (sel < 40) begin
      case ($urandom_range(0, 4))
        0: return 11'd0;
        1: return 11'd1;
        2: return 11'd47;
        3: return 11'd48;
        default: return 11'h7FF;
      endcase
    end
    return 11'($urandom_range(0, 2047));
  endfunction

  // short pauses keep the countdown moving; a full queue drops the entry,
  // so any 16-bit pause is safe there
  function automatic logic [15:0] rand_pause();
    int unsigned sel;
    if (beep_fill >= QDEPTH) return 16'($urandom_range(0, 65535));
    sel = $urandom_range(0, 99);
    if (sel < 50) return 16'd0;
    if (sel < 85) return 16'($urandom_range(1, 3));
    return 16'($urandom_range(4, 15));
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_req(logic [1:0] cmd, logic [10:0] val, logic [15:0] pause,
                          bit fixed, result_t fixed_res);
    int unsigned gap;
    result_t pred;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, pause, val};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_frame(cmd, val, pause);
    expected_frames.push_back(fixed ? fixed_res : pred);
    if (cmd != CMD_UNUSED) req_count++;
  endtask

  task automatic send(logic [1:0] cmd, logic [10:0] val, logic [15:0] pause);
    send_req(cmd, val, pause, 1'b0, '0);
  endtask

  // stop offering and let every outstanding result drain
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(int unsigned idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_INVERT_MODE) inv_mode = data[0];
  endtask

  // result side back-pressure, with a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= (rx_hold == 1);
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold       <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold       <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_mon
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got tdata 0x%0h tuser 0x%0h",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_sent", 32'(want.frame_sent), 32'(m_axis_tuser[0]));
        check_field("frame", 32'(want.frame), 32'(m_axis_tdata[15:0]));
        check_field("line_word", 32'(want.line_word), 32'(m_axis_tdata[31:16]));
        check_field("entry_dropped", 32'(want.entry_dropped), 32'(m_axis_tuser[1]));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned target;
    bit          paused;

    inv_mode    = 1'b0;
    thr_setting = '0;
    pause_left  = '0;
    beep_head   = '0;
    beep_fill   = '0;

    // directed table
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'h0000, 16'h0000, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_UNUSED, 11'h7FF, 16'hFFFF, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_THROTTLE, 11'h7FF, 0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'hFFEE, 16'hFFEE, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_THROTTLE, 11'd47, 0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'h05FA, 16'h05FA, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_THROTTLE, 11'd48, 0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'h0606, 16'h0606, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_THROTTLE, 11'd1, 0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'h0033, 16'h0033, 0)));
    // queued beeps: pause countdown, then a zero pause
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'h7FF, 16'd2, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'd0, 16'd0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'hFFFF, 16'hFFFF, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 2, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'h0011, 16'h0011, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 0, '0));
    // fill the queue and overflow it
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'h555, 16'd1, QDEPTH, 0, '0));
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'h2AA, 16'hFFFF, 1, 1, res(0, 0, 0, 1)));
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'h555, 16'hAAAA, 1, 1, res(0, 0, 0, 1)));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 2 * QDEPTH, 0, '0));
    // inverted mode
    dir_table.push_back(row(ROW_CFG, CMD_TICK, 11'd1, 0, 1, 0, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 0, '0));
    dir_table.push_back(row(ROW_REQ, CMD_THROTTLE, 11'h7FF, 0, 1, 1, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 1, 1, res(1, 16'hFFE1, 16'h001E, 0)));
    dir_table.push_back(row(ROW_REQ, CMD_BEEP, 11'd47, 0, 1, 0, '0));
    dir_table.push_back(row(ROW_REQ, CMD_TICK, 0, 0, 2, 0, '0));
    dir_table.push_back(row(ROW_CFG, CMD_TICK, 11'd0, 0, 1, 0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        quiesce();
        apb_write(REG_INVERT_MODE, 32'(dir_table[i].val));
      end else begin
        repeat (dir_table[i].reps)
          send_req(dir_table[i].cmd, dir_table[i].val, dir_table[i].pause,
                   dir_table[i].fixed, dir_table[i].res);
      end
    end

    // random phases, each with its own mode and idling profile
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      apb_write(REG_INVERT_MODE, 32'(ph % 2));
      case (ph)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 20; rx_stall_pct = 20; end
        2: begin tx_gap_pct = 10; rx_stall_pct = 40; end
        3: begin tx_gap_pct = 50; rx_stall_pct = 10; end
        4: begin tx_gap_pct = 30; rx_stall_pct = 30; end
        5: begin tx_gap_pct = 0;  rx_stall_pct = 30; end
        6: begin tx_gap_pct = 30; rx_stall_pct = 0;  end
        default: begin tx_gap_pct = 15; rx_stall_pct = 15; end
      endcase
      // result side stalls for a long stretch while requests keep coming
      if (ph == 2) long_hold_req = 1'b1;
      // one long pause to run the countdown well past a nibble
      if (ph == 5) send(CMD_BEEP, rand_value(), 16'd300);
      target = req_count + PHASE_REQS;
      paused = 1'b0;
      while (req_count < target) begin
        if (ph == 4 && !paused && req_count + PHASE_REQS / 2 >= target) begin
          quiesce();
          paused = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
          repeat ($urandom_range(4, 18)) send(CMD_BEEP, rand_value(), rand_pause());
        end else if (sel < 7) begin
          repeat ($urandom_range(20, 40))
            send(CMD_TICK, 11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)));
        end else if (sel < 17) begin
          send(CMD_THROTTLE, rand_value(), 16'($urandom_range(0, 65535)));
        end else if (sel < 21) begin
          send(CMD_UNUSED, 11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)));
        end else if (sel < 45) begin
          send(CMD_BEEP, rand_value(), rand_pause());
        end else begin
          send(CMD_TICK, 11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)));
        end
      end
    end

    // drain, then load the largest pause and count a few ticks of it
    quiesce();
    while (beep_fill != 0 || pause_left != 0) send(CMD_TICK, 0, 0);
    send(CMD_BEEP, 11'h2AA, 16'hFFFF);
    repeat (4) send(CMD_TICK, 0, 0);
    s_axis_tvalid <= 1'b0;

    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: dshot_command_scheduler.f
rtl/dshot_cs_pkg.sv
rtl/dshot_cs_front.sv
rtl/dshot_cs_back.sv
rtl/dshot_command_scheduler.sv
rtl/dshot_cs_checker.sv
tb/sv/dshot_command_scheduler_tb.sv
